// ===== design/bsh_pkg.sv =====
// ----------------------------------------------------------------------------
// bsh_pkg - shared types and functions of the byte string hash
// Constants, the command word between the front and back halves, and one
// round of the three-word mix.
// ----------------------------------------------------------------------------
`default_nettype none

package bsh_pkg;

   localparam logic [31:0] GOLDEN_WORD = 32'h9e3779b9;
   localparam logic [31:0] SEED_RESET  = 32'habcdef89;
   localparam int          BLOCK_SIZE  = 12;
   localparam int          QUEUE_DEPTH = 2;
   localparam int          MIX_STEPS   = 9;
   localparam logic [3:0]  LAST_STEP   = 4'(MIX_STEPS - 1);

   typedef struct packed {
      logic        first;
      logic        blk;
      logic        fin;
      logic [31:0] seed;
      logic [31:0] blk_a;
      logic [31:0] blk_b;
      logic [31:0] blk_c;
      logic [31:0] fin_a;
      logic [31:0] fin_b;
      logic [31:0] fin_c;
   } cmd_type;

   function automatic logic [4:0] mix_shift(input logic [3:0] step);
      logic [4:0] s;
      unique case (step)
         4'd0:    s = 5'd13;
         4'd1:    s = 5'd8;
         4'd2:    s = 5'd13;
         4'd3:    s = 5'd12;
         4'd4:    s = 5'd16;
         4'd5:    s = 5'd5;
         4'd6:    s = 5'd3;
         4'd7:    s = 5'd10;
         4'd8:    s = 5'd15;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // one round of the mix: returns {c, b, a}
   function automatic logic [95:0] mix_step(input logic [31:0] a,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [3:0]  step);
      logic [31:0] an;
      logic [31:0] bn;
      logic [31:0] cn;
      logic [4:0]  s;
      s  = mix_shift(step);
      an = a;
      bn = b;
      cn = c;
      unique case (step)
         4'd0, 4'd3, 4'd6: an = (a - b - c) ^ (c >> s);
         4'd1, 4'd4, 4'd7: bn = (b - c - a) ^ (a << s);
         default:          cn = (c - a - b) ^ (b >> s);
      endcase
      return {cn, bn, an};
   endfunction

endpackage

`default_nettype wire

// ===== design/bsh_front.sv =====
// ----------------------------------------------------------------------------
// bsh_front - byte intake of the byte string hash
// Gathers bytes into blocks, counts the length, holds the seed and issues
// one command per word that completes a block or ends a string.
// ----------------------------------------------------------------------------
`default_nettype none

module bsh_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire logic [7:0]      data_byte,
   input  wire logic            byte_valid,
   input  wire logic            last,
   input  wire logic            csr_write,
   input  wire logic [31:0]     csr_value,
   output bsh_pkg::cmd_type     cmd,
   output logic                 cmd_push
);

   logic [7:0]  bytes_ff [bsh_pkg::BLOCK_SIZE];
   logic [7:0]  bytes_in [bsh_pkg::BLOCK_SIZE];
   logic [3:0]  fill_ff;
   logic [3:0]  fill_in;
   logic [31:0] length_ff;
   logic [31:0] length_in;
   logic        first_ff;
   logic        first_in;
   logic [31:0] init_value_ff;
   logic [31:0] init_value_in;
   logic [31:0] seed_ff;
   logic [31:0] seed_in;

   logic        take;
   logic        do_blk;
   logic        do_fin;
   logic [3:0]  fill_next;
   logic [31:0] length_next;
   logic [7:0]  kept [bsh_pkg::BLOCK_SIZE];

   always_comb begin
      take        = accept && byte_valid;
      do_blk      = take && (fill_ff == 4'(bsh_pkg::BLOCK_SIZE - 1));
      do_fin      = accept && last;
      fill_next   = take ? fill_ff + 4'd1 : fill_ff;
      length_next = take ? length_ff + 32'd1 : length_ff;

      for (int i = 0; i < bsh_pkg::BLOCK_SIZE; i++) begin
         bytes_in[i] = bytes_ff[i];
         if (take && (fill_ff == 4'(i))) begin
            bytes_in[i] = data_byte;
         end
         kept[i] = (4'(i) < fill_next) ? bytes_in[i] : 8'h00;
      end

      if (do_fin) begin
         fill_in = 4'd0;
      end else if (do_blk) begin
         fill_in = 4'd0;
      end else begin
         fill_in = fill_next;
      end
      length_in = do_fin ? 32'd0 : length_next;
      first_in  = do_fin ? 1'b1 : (do_blk ? 1'b0 : first_ff);

      init_value_in = csr_write ? csr_value : init_value_ff;
      seed_in       = seed_ff;
      if (csr_write && (fill_ff == 4'd0) && (length_ff == 32'd0)) begin
         seed_in = csr_value;
      end else if (do_fin) begin
         seed_in = init_value_ff;
      end

      cmd.first = first_ff;
      cmd.blk   = do_blk;
      cmd.fin   = do_fin;
      cmd.seed  = seed_ff;
      cmd.blk_a = {bytes_in[3], bytes_in[2], bytes_in[1], bytes_in[0]};
      cmd.blk_b = {bytes_in[7], bytes_in[6], bytes_in[5], bytes_in[4]};
      cmd.blk_c = {bytes_in[11], bytes_in[10], bytes_in[9], bytes_in[8]};
      if (do_blk) begin
         cmd.fin_a = 32'd0;
         cmd.fin_b = 32'd0;
         cmd.fin_c = length_next;
      end else begin
         cmd.fin_a = {kept[3], kept[2], kept[1], kept[0]};
         cmd.fin_b = {kept[7], kept[6], kept[5], kept[4]};
         cmd.fin_c = {kept[10], kept[9], kept[8], 8'h00} + length_next;
      end
      cmd_push = do_blk || do_fin;
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      if (reset) begin
         fill_ff       <= 4'd0;
         length_ff     <= 32'd0;
         first_ff      <= 1'b1;
         init_value_ff <= bsh_pkg::SEED_RESET;
         seed_ff       <= bsh_pkg::SEED_RESET;
      end else begin
         fill_ff       <= fill_in;
         length_ff     <= length_in;
         first_ff      <= first_in;
         init_value_ff <= init_value_in;
         seed_ff       <= seed_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/bsh_fifo.sv =====
// ----------------------------------------------------------------------------
// bsh_fifo - command queue of the byte string hash
// Small register queue that decouples the byte intake from the mix unit.
// ----------------------------------------------------------------------------
`default_nettype none

module bsh_fifo #(
   parameter int DEPTH = bsh_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire bsh_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output bsh_pkg::cmd_type      pop_cmd,
   output logic                  not_empty,
   output logic                  full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bsh_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      not_empty = (count_ff != '0);
      full      = (count_ff == CNT_W'(DEPTH));
      pop_cmd   = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/bsh_mix.sv =====
// ----------------------------------------------------------------------------
// bsh_mix - mix unit of the byte string hash
// Takes queued commands, adds their words to the accumulators and runs the
// mix one round per cycle unless a held hash stalls; registers each hash.
// ----------------------------------------------------------------------------
`default_nettype none

module bsh_mix (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bsh_pkg::cmd_type cmd,
   input  wire logic             cmd_valid,
   output logic                  cmd_pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [31:0]           rsp_tdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_MIX  = 1'b1;

   logic        state_ff;
   logic        state_in;
   logic [3:0]  step_ff;
   logic [3:0]  step_in;
   logic        final_ff;
   logic        final_in;
   logic        pend_ff;
   logic        pend_in;
   logic [31:0] acc_a_ff;
   logic [31:0] acc_a_in;
   logic [31:0] acc_b_ff;
   logic [31:0] acc_b_in;
   logic [31:0] acc_c_ff;
   logic [31:0] acc_c_in;
   logic [95:0] fin_ff;
   logic [95:0] fin_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] rsp_data_ff;
   logic [31:0] rsp_data_in;

   logic [31:0] base_a;
   logic [31:0] base_b;
   logic [31:0] base_c;
   logic [95:0] res;
   logic        out_free;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      cmd_pop  = cmd_valid && (state_ff == ST_IDLE);
      res      = bsh_pkg::mix_step(acc_a_ff, acc_b_ff, acc_c_ff, step_ff);

      base_a = cmd.first ? bsh_pkg::GOLDEN_WORD : acc_a_ff;
      base_b = cmd.first ? bsh_pkg::GOLDEN_WORD : acc_b_ff;
      base_c = cmd.first ? cmd.seed : acc_c_ff;

      state_in     = state_ff;
      step_in      = step_ff;
      final_in     = final_ff;
      pend_in      = pend_ff;
      acc_a_in     = acc_a_ff;
      acc_b_in     = acc_b_ff;
      acc_c_in     = acc_c_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               state_in = ST_MIX;
               step_in  = 4'd0;
               fin_in   = {cmd.fin_c, cmd.fin_b, cmd.fin_a};
               if (cmd.blk) begin
                  acc_a_in = base_a + cmd.blk_a;
                  acc_b_in = base_b + cmd.blk_b;
                  acc_c_in = base_c + cmd.blk_c;
                  final_in = 1'b0;
                  pend_in  = cmd.fin;
               end else begin
                  acc_a_in = base_a + cmd.fin_a;
                  acc_b_in = base_b + cmd.fin_b;
                  acc_c_in = base_c + cmd.fin_c;
                  final_in = 1'b1;
                  pend_in  = 1'b0;
               end
            end
         end
         ST_MIX: begin
            if (step_ff != bsh_pkg::LAST_STEP) begin
               {acc_c_in, acc_b_in, acc_a_in} = res;
               step_in = step_ff + 4'd1;
            end else if (!final_ff && pend_ff) begin
               acc_a_in = res[31:0] + fin_ff[31:0];
               acc_b_in = res[63:32] + fin_ff[63:32];
               acc_c_in = res[95:64] + fin_ff[95:64];
               final_in = 1'b1;
               pend_in  = 1'b0;
               step_in  = 4'd0;
            end else if (final_ff) begin
               if (out_free) begin
                  {acc_c_in, acc_b_in, acc_a_in} = res;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = res[95:64];
                  state_in     = ST_IDLE;
                  step_in      = 4'd0;
               end
            end else begin
               {acc_c_in, acc_b_in, acc_a_in} = res;
               state_in = ST_IDLE;
               step_in  = 4'd0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      acc_a_ff    <= acc_a_in;
      acc_b_ff    <= acc_b_in;
      acc_c_ff    <= acc_c_in;
      fin_ff      <= fin_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 4'd0;
         final_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         final_ff     <= final_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (step_ff == 4'd0))
      else $error("step counter not cleared in idle");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= bsh_pkg::LAST_STEP)
      else $error("mix step out of range");

   a_emit_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MIX && final_ff
                                    && step_ff == bsh_pkg::LAST_STEP))
      else $error("hash emitted outside the last round of a final mix");

   a_pend_block: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !final_ff)
      else $error("pending string end during final mix");
`endif

endmodule

`default_nettype wire

// ===== design/byte_string_hash.sv =====
// ----------------------------------------------------------------------------
// byte_string_hash - 32-bit lookup2 hash of a byte stream
// Byte intake, command queue and iterative mix unit.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tdata data_byte, tuser byte_valid, tlast
//  rsp      out  rsp_tvalid/rsp_tready  tdata hash_value
//  csr      in   csr_valid/csr_ready    csr_data init_value
//
//  Input words are taken one per cycle while the command queue has room.
//  A word that fills a block or ends a string queues one command; the mix
//  unit adds its words, runs nine rounds, and when the word also ends the
//  string, adds the end words and runs nine rounds again. The shared mix
//  round sets the rate of short strings. Reset is synchronous; a held result
//  does not stop intake, only the last round of the next string end.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_string_hash #(
   parameter int QUEUE_DEPTH = bsh_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] data_byte
   input  wire logic        req_tuser,    // [0] byte_valid
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,    // [31:0] hash_value
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   bsh_pkg::cmd_type push_cmd;
   bsh_pkg::cmd_type pop_cmd;
   logic             push;
   logic             pop;
   logic             not_empty;
   logic             full;
   logic             accept;

   assign req_tready = !full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;

   bsh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_tdata),
      .byte_valid (req_tuser),
      .last       (req_tlast),
      .csr_write  (csr_valid && csr_ready),
      .csr_value  (csr_data),
      .cmd        (push_cmd),
      .cmd_push   (push)
   );

   bsh_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .pop_cmd   (pop_cmd),
      .not_empty (not_empty),
      .full      (full)
   );

   bsh_mix u_mix (
      .clock      (clock),
      .reset      (reset),
      .cmd        (pop_cmd),
      .cmd_valid  (not_empty),
      .cmd_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== dv/byte_string_hash_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_string_hash_test - self-checking bench for the byte string hash
// Streams byte strings into the hash block and compares each hash that comes
// out against a local model of the lookup2 scheme. The run starts with a few
// fixed strings: empty, one byte, one full block and a partial block. Random
// strings follow under three seeds. The all-zero and all-one seeds are among
// them. Each seed setting uses a different idle pattern on the two streams.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last;
} byte_word_type;

class hash_scoreboard;
   logic [31:0] seed;
   logic [31:0] acc_a;
   logic [31:0] acc_b;
   logic [31:0] acc_c;
   logic [31:0] string_length;
   logic [7:0]  held_bytes [bsh_pkg::BLOCK_SIZE];
   int unsigned held_count;
   logic [31:0] expected_hashes [$];
   int unsigned mismatches;
   int unsigned strings_done;
   int unsigned bytes_taken;

   function new();
      seed = bsh_pkg::SEED_RESET;
      foreach (held_bytes[i]) held_bytes[i] = 8'h00;
      mismatches   = 0;
      strings_done = 0;
      bytes_taken  = 0;
      restart();
   endfunction

   function void restart();
      acc_a         = bsh_pkg::GOLDEN_WORD;
      acc_b         = bsh_pkg::GOLDEN_WORD;
      acc_c         = seed;
      held_count    = 0;
      string_length = 32'd0;
   endfunction

   function void set_seed(input logic [31:0] value);
      seed = value;
      if (string_length == 32'd0 && held_count == 0) acc_c = seed;
   endfunction

   function void mix3(inout logic [31:0] a, inout logic [31:0] b, inout logic [31:0] c);
      a = (a - b - c) ^ (c >> 13);
      b = (b - c - a) ^ (a << 8);
      c = (c - a - b) ^ (b >> 13);
      a = (a - b - c) ^ (c >> 12);
      b = (b - c - a) ^ (a << 16);
      c = (c - a - b) ^ (b >> 5);
      a = (a - b - c) ^ (c >> 3);
      b = (b - c - a) ^ (a << 10);
      c = (c - a - b) ^ (b >> 15);
   endfunction

   function logic [31:0] block_word(input int base);
      return {held_bytes[base + 3], held_bytes[base + 2],
              held_bytes[base + 1], held_bytes[base]};
   endfunction

   function void note_word(input byte_word_type w);
      logic [31:0] v;
      int          sh;
      if (w.byte_valid) begin
         held_bytes[held_count] = w.data_byte;
         held_count++;
         string_length++;
         bytes_taken++;
         if (held_count == bsh_pkg::BLOCK_SIZE) begin
            acc_a += block_word(0);
            acc_b += block_word(4);
            acc_c += block_word(8);
            mix3(acc_a, acc_b, acc_c);
            held_count = 0;
         end
      end
      if (w.last) begin
         acc_c += string_length;
         for (int i = 0; i < held_count && i < bsh_pkg::BLOCK_SIZE - 1; i++) begin
            v  = {24'd0, held_bytes[i]};
            sh = (i % 4) * 8;
            if (i < 4)
               acc_a += v << sh;
            else if (i < 8)
               acc_b += v << sh;
            else
               acc_c += v << (sh + 8);
         end
         mix3(acc_a, acc_b, acc_c);
         expected_hashes.push_back(acc_c);
         strings_done++;
         restart();
      end
   endfunction

   function void check_hash(input logic [31:0] actual);
      logic [31:0] want;
      if (expected_hashes.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected hash_value %h", actual);
      end else begin
         want = expected_hashes.pop_front();
         if (actual !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("hash_value mismatch: expected %h actual %h", want, actual);
         end
      end
   endfunction

   function int unsigned pending();
      return expected_hashes.size();
   endfunction
endclass

module byte_string_hash_test;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 64;
   localparam int PHASE_WORDS  = 650;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data   = 32'd0;

   hash_scoreboard sb;
   int unsigned    send_idle = 25;
   int unsigned    recv_idle = 64;
   int unsigned    counted   = 0;
   int unsigned    seeds_set = 1;
   int unsigned    cycle_count;

   always #2 clock = ~clock;

   byte_string_hash dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] data_byte
      .req_tuser  (req_tuser),    // [0] byte_valid
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [31:0] hash_value
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_hash(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_word(input logic [7:0] data_byte, input logic byte_valid,
                            input logic last);
      byte_word_type w;
      w.data_byte  = data_byte;
      w.byte_valid = byte_valid;
      w.last       = last;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data_byte;
      req_tuser  <= byte_valid;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_word(w);
      counted++;
   endtask

   task automatic drain(input int hold);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (hold) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_seed(value);
      seeds_set++;
   endtask

   task automatic send_string();
      int unsigned len;
      bit          end_on_byte;
      len         = ($urandom_range(0, 15) == 0) ? $urandom_range(31, 80)
                                                 : $urandom_range(0, 30);
      end_on_byte = $urandom_range(0, 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) send_word(random_byte(), 1'b0, 1'b0);
         send_word(random_byte(), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte || len == 0) send_word(random_byte(), 1'b0, 1'b1);
   endtask

   task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle,
                            input logic [31:0] seed);
      int unsigned start;
      drain(DRAIN_CYCLES);
      write_seed(seed);
      send_idle = s_idle;
      recv_idle = r_idle;
      start     = counted;
      while (counted - start < PHASE_WORDS) send_string();
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty string, idle word, single byte with last
      send_word(8'h00, 1'b0, 1'b1);
      send_word(8'h5a, 1'b0, 1'b0);
      send_word(8'hff, 1'b1, 1'b1);
      // full block closed by its last byte
      for (int i = 0; i < 12; i++)
         send_word((i % 2) ? 8'hff : 8'h00, 1'b1, i == 11);
      // partial block reaching into c, closed by an end marker
      for (int i = 0; i < 10; i++)
         send_word(8'(1 << (i % 8)), 1'b1, 1'b0);
      send_word(8'ha5, 1'b0, 1'b0);
      send_word(8'h3c, 1'b0, 1'b1);

      run_phase(25, 64, 32'h0000_0000);
      run_phase(64, 25, 32'hffff_ffff);
      run_phase(0, 0, 32'($urandom()));
      drain(DRAIN_CYCLES);

      $display("Hashed %0d strings of %0d bytes in total under %0d seed values",
               sb.strings_done, sb.bytes_taken, seeds_set);
      $display("Streams ran sender-heavy, receiver-heavy and unthrottled; %0d mismatches",
               sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
